/* design/tfe_pkg.sv */
// shared types and constants for the touch fling estimator
`default_nettype none

package tfe_pkg;

    // default depth of the sample window
    localparam int WINDOW_DEFAULT = 5;

    // register reset values
    localparam logic [15:0] THRESH_RESET = 16'd10;
    localparam logic [15:0] GAIN_RESET   = 16'd256;

    // register indexes on the configuration port
    localparam logic CFG_THRESH = 1'b0;
    localparam logic CFG_GAIN   = 1'b1;

    // milliseconds per second, sized for the distance product
    localparam logic [25:0] MS_PER_SECOND = 26'd1000;

    // dividend width: |dist| * 1000 * gain / 256
    localparam int NUM_W     = 34;
    localparam int DIV_STEPS = NUM_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    // transaction action codes
    typedef enum logic [1:0] {
        ACT_ADD     = 2'd0,
        ACT_QUERY_Y = 2'd1,
        ACT_QUERY_X = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    // one stored touch sample
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [31:0]        t;
    } t_sample;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic add_write;
        logic rd_newest;
        logic lat_newest;
        logic walk;
        logic mul_a;
        logic mul_b;
        logic div_step;
        logic out_load;
        logic out_zero;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        t_action act;
        logic    cnt_lt2;
        logic    hit;
        logic    div_done;
        logic    out_free;
    } t_status;

endpackage

`default_nettype wire

/* design/tfe_ctrl.sv */
// controller state machine for the touch fling estimator
`default_nettype none

module tfe_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire tfe_pkg::t_status i_status,
    output tfe_pkg::t_cmd        o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_ADD,
        S_LAT_NEW,
        S_WALK,
        S_MUL_A,
        S_MUL_B,
        S_DIV,
        S_OUT,
        S_ZERO
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // next state and command decode
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_status.act)
                    tfe_pkg::ACT_ADD: n_state = S_ADD;
                    tfe_pkg::ACT_QUERY_Y, tfe_pkg::ACT_QUERY_X: begin
                        if (i_status.cnt_lt2) begin
                            n_state = S_ZERO;
                        end else begin
                            o_cmd.rd_newest = 1'b1;
                            n_state         = S_LAT_NEW;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_ADD: begin
                o_cmd.add_write = 1'b1;
                n_state         = S_IDLE;
            end
            S_LAT_NEW: begin
                o_cmd.lat_newest = 1'b1;
                n_state          = S_WALK;
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_status.hit) begin
                    n_state = S_MUL_A;
                end
            end
            S_MUL_A: begin
                o_cmd.mul_a = 1'b1;
                n_state     = S_MUL_B;
            end
            S_MUL_B: begin
                o_cmd.mul_b = 1'b1;
                n_state     = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_ZERO: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_zero = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

/* design/tfe_datapath.sv */
// sample window, walk back, velocity product, serial divider and output register
`default_nettype none

module tfe_datapath #(
    parameter int WINDOW = tfe_pkg::WINDOW_DEFAULT
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire tfe_pkg::t_cmd      i_cmd,
    output tfe_pkg::t_status        o_status,
    input  wire logic [1:0]         i_action,
    input  wire logic signed [15:0] i_pos_x,
    input  wire logic signed [15:0] i_pos_y,
    input  wire logic [31:0]        i_time_ms,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_index,
    input  wire logic [15:0]        i_cfg_data,
    input  wire logic               i_out_ready,
    output logic                    o_out_valid,
    output logic                    o_fling_valid,
    output logic signed [31:0]      o_fling_distance,
    output logic [31:0]             o_elapsed_ms
);

    localparam int IW = $clog2(WINDOW);
    localparam int CW = $clog2(WINDOW + 1);
    localparam logic [CW-1:0] COUNT_FULL = CW'(WINDOW);
    localparam logic [IW:0]   WRAP       = (IW + 1)'(WINDOW);
    localparam int NW = tfe_pkg::NUM_W;
    localparam int DW = tfe_pkg::DCNT_W;
    localparam logic [DW-1:0] DCNT_LAST  = DW'(tfe_pkg::DIV_STEPS - 1);

    // logical index (0 = oldest) to memory address in the circular buffer
    function automatic logic [IW-1:0] phys(input logic [IW-1:0] head,
                                           input logic [IW-1:0] lidx);
        logic [IW:0] s;
        s = {1'b0, head} + {1'b0, lidx};
        if (s >= WRAP) begin
            s = s - WRAP;
        end
        return s[IW-1:0];
    endfunction

    // captured transaction and registers
    tfe_pkg::t_action   r_act;
    tfe_pkg::t_sample   r_in;
    logic [15:0]        r_thresh;
    logic [15:0]        r_gain;

    // window bookkeeping
    logic [IW-1:0]      r_head;
    logic [CW-1:0]      r_count;
    logic [IW-1:0]      r_idx;
    tfe_pkg::t_sample   mem [WINDOW];
    tfe_pkg::t_sample   r_rd;
    tfe_pkg::t_sample   r_new;

    // chosen sample and arithmetic
    logic [15:0]        r_mag;
    logic               r_neg;
    logic [31:0]        r_elapsed;
    logic [25:0]        r_prod_a;
    logic [NW-1:0]      r_quo;
    logic [31:0]        r_rem;
    logic [DW-1:0]      r_dcnt;

    // output register
    logic               r_out_valid;
    logic               r_fv;
    logic signed [31:0] r_fd;
    logic [31:0]        r_el;

    logic [CW-1:0]      cnt_m1;
    logic [CW-1:0]      cnt_m2;
    logic [IW-1:0]      rd_addr;
    logic [IW-1:0]      wr_addr;
    logic               full;
    logic signed [15:0] axis_a;
    logic signed [15:0] axis_b;
    logic signed [16:0] delta;
    logic [16:0]        mag17;
    logic               hit;
    logic [41:0]        prod_b;
    logic [32:0]        rem_sh;
    logic [33:0]        diff;
    logic               ge;
    logic [34:0]        total;
    logic [34:0]        limit;
    logic [34:0]        sat;
    logic [31:0]        mag32;
    logic [31:0]        fd;

    assign full   = (r_count == COUNT_FULL);
    assign cnt_m1 = r_count - CW'(1);
    assign cnt_m2 = r_count - CW'(2);

    // read address: newest, current walk entry, or the next one back
    always_comb begin
        if (i_cmd.rd_newest) begin
            rd_addr = phys(r_head, cnt_m1[IW-1:0]);
        end else if (i_cmd.walk) begin
            rd_addr = phys(r_head, r_idx - IW'(1));
        end else begin
            rd_addr = phys(r_head, r_idx);
        end
    end

    assign wr_addr = full ? r_head : phys(r_head, r_count[IW-1:0]);

    // distance on the queried axis
    assign axis_a = (r_act == tfe_pkg::ACT_QUERY_Y) ? r_new.y : r_new.x;
    assign axis_b = (r_act == tfe_pkg::ACT_QUERY_Y) ? r_rd.y : r_rd.x;
    assign delta  = {axis_a[15], axis_a} - {axis_b[15], axis_b};
    assign mag17  = delta[16] ? 17'(-delta) : 17'(delta);
    assign hit    = (mag17 > {1'b0, r_thresh}) || (r_idx == '0);

    // second product stage, gain is Q8.8
    assign prod_b = {16'd0, r_prod_a} * {26'd0, r_gain};

    // restoring divide step
    assign rem_sh = {r_rem, r_quo[NW-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, r_elapsed};
    assign ge     = ~diff[33];

    // add velocity term and saturate
    assign total = {19'd0, r_mag} + {1'b0, r_quo};
    assign limit = r_neg ? 35'h0_8000_0000 : 35'h0_7FFF_FFFF;
    assign sat   = (total > limit) ? limit : total;
    assign mag32 = (r_elapsed == '0) ? limit[31:0] : sat[31:0];
    assign fd    = (r_mag == '0) ? 32'd0 : (r_neg ? (32'd0 - mag32) : mag32);

    assign o_status.act      = r_act;
    assign o_status.cnt_lt2  = (r_count < CW'(2));
    assign o_status.hit      = hit;
    assign o_status.div_done = (r_dcnt == DCNT_LAST);
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid      = r_out_valid;
    assign o_fling_valid    = r_fv;
    assign o_fling_distance = r_fd;
    assign o_elapsed_ms     = r_el;

    // sample memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.add_write) begin
            mem[wr_addr] <= r_in;
        end
        r_rd <= mem[rd_addr];
    end

    // control state: registers, window pointers, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh    <= tfe_pkg::THRESH_RESET;
            r_gain      <= tfe_pkg::GAIN_RESET;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    tfe_pkg::CFG_THRESH: r_thresh <= i_cfg_data;
                    tfe_pkg::CFG_GAIN:   r_gain   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.add_write) begin
                if (full) begin
                    r_head <= (r_head == IW'(WINDOW - 1)) ? '0 : r_head + IW'(1);
                end else begin
                    r_count <= r_count + CW'(1);
                end
            end
            if (i_cmd.out_load && !i_cmd.out_zero) begin
                r_count <= '0;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: capture, walk, multiply, divide, result
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_act  <= tfe_pkg::t_action'(i_action);
            r_in.x <= i_pos_x;
            r_in.y <= i_pos_y;
            r_in.t <= i_time_ms;
        end
        if (i_cmd.rd_newest) begin
            r_idx <= cnt_m2[IW-1:0];
        end
        if (i_cmd.lat_newest) begin
            r_new <= r_rd;
        end
        if (i_cmd.walk) begin
            r_idx     <= r_idx - IW'(1);
            r_mag     <= mag17[15:0];
            r_neg     <= delta[16];
            r_elapsed <= r_new.t - r_rd.t;
        end
        if (i_cmd.mul_a) begin
            r_prod_a <= 26'(r_mag * tfe_pkg::MS_PER_SECOND);
        end
        if (i_cmd.mul_b) begin
            r_quo  <= prod_b[41:8];
            r_rem  <= '0;
            r_dcnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem  <= ge ? diff[31:0] : rem_sh[31:0];
            r_quo  <= {r_quo[NW-2:0], ge};
            r_dcnt <= r_dcnt + DW'(1);
        end
        if (i_cmd.out_load) begin
            r_fv <= !i_cmd.out_zero;
            r_fd <= i_cmd.out_zero ? 32'sd0 : signed'(fd);
            r_el <= i_cmd.out_zero ? 32'd0 : r_elapsed;
        end
    end

`ifndef ASSERT_OFF
    // a new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over a pending result");

    // a computed fling empties the window
    a_empty_after_fling: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_load && !i_cmd.out_zero) |=> (r_count == '0))
        else $error("window not emptied after fling");

    // the fill count never passes the window depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_FULL)
        else $error("sample count exceeds window");

    // adding to a full window keeps it full
    a_full_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.add_write && full) |=> (r_count == COUNT_FULL))
        else $error("full window lost a sample on add");
`endif

endmodule

`default_nettype wire

/* design/touch_fling_estimator.sv */
// top level of the touch fling estimator
`default_nettype none

// Touch fling estimator. Add transactions store a touch sample (x, y,
// millisecond time) in a WINDOW-deep circular buffer, dropping the oldest
// once full. A query on x or y walks back from the newest sample one entry
// per cycle through the registered-read sample memory, stops at the first
// sample farther than distance_threshold or at the oldest, and returns
// dist + dist*1000*gain/(256*elapsed) saturated to 32 bits, then empties the
// window. The quotient comes from a one-bit-per-cycle divider. A query with
// fewer than two samples returns an invalid zero result. Results sit in an
// output register, so the next transaction is taken while a result waits.
// Registers are written on the cfg port any time the block is idle.
module touch_fling_estimator #(
    parameter int WINDOW = tfe_pkg::WINDOW_DEFAULT
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [1:0]         i_action,
    input  wire logic signed [15:0] i_pos_x,
    input  wire logic signed [15:0] i_pos_y,
    input  wire logic [31:0]        i_time_ms,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic                    o_fling_valid,
    output logic signed [31:0]      o_fling_distance,
    output logic [31:0]             o_elapsed_ms,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_index,
    input  wire logic [15:0]        i_cfg_data
);

    tfe_pkg::t_cmd    cmd;
    tfe_pkg::t_status status;

    // sequencing
    tfe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // storage and arithmetic
    tfe_datapath #(
        .WINDOW (WINDOW)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_action         (i_action),
        .i_pos_x          (i_pos_x),
        .i_pos_y          (i_pos_y),
        .i_time_ms        (i_time_ms),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_fling_valid    (o_fling_valid),
        .o_fling_distance (o_fling_distance),
        .o_elapsed_ms     (o_elapsed_ms)
    );

endmodule

`default_nettype wire

/* tb/sv/tfe_fling_checker.sv */
// checker that predicts and compares the fling results of the touch fling estimator
`timescale 1ns / 1ps

module tfe_fling_checker
    import tfe_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [1:0]         i_action,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic [31:0]        i_time_ms,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic               i_fling_valid,
    input  logic signed [31:0] i_fling_distance,
    input  logic [31:0]        i_elapsed_ms,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int DEPTH = WINDOW_DEFAULT;

    // one predicted query result
    typedef struct packed {
        logic               valid;
        logic signed [31:0] distance;
        logic [31:0]        elapsed;
    } t_fling;

    // predicted touch history and register copies
    logic signed [15:0] hist_x [DEPTH];
    logic signed [15:0] hist_y [DEPTH];
    logic [31:0]        hist_t [DEPTH];
    int                 hist_count;
    logic [15:0]        thresh;
    logic [15:0]        gain;
    t_fling             expected_flings [$];

    // delta + delta*1000*gain/(256*elapsed), saturated to 32 bits signed
    function automatic logic signed [31:0] saturated_fling(logic signed [16:0] delta,
                                                           logic [31:0] elapsed);
        logic [16:0] mag;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] total;
        logic [63:0] limit;
        mag   = delta[16] ? 17'(-delta) : 17'(delta);
        limit = delta[16] ? 64'd2147483648 : 64'd2147483647;
        if (mag == 0)
            return 32'sd0;
        if (elapsed == 0) begin
            total = limit;
        end else begin
            num   = 64'(mag) * 64'd1000 * 64'(gain);
            den   = 64'(elapsed) * 64'd256;
            total = 64'(mag) + num / den;
            if (total > limit)
                total = limit;
        end
        return delta[16] ? 32'(64'd0 - total) : 32'(total);
    endfunction

    // walk back from the newest sample to the first one beyond the threshold
    function automatic t_fling predict_fling(logic on_y);
        t_fling             res;
        int                 newest;
        logic signed [16:0] delta;
        logic [16:0]        mag;
        res = '0;
        if (hist_count < 2)
            return res;
        newest = hist_count - 1;
        for (int i = newest - 1; i >= 0; i--) begin
            if (on_y)
                delta = {hist_y[newest][15], hist_y[newest]} - {hist_y[i][15], hist_y[i]};
            else
                delta = {hist_x[newest][15], hist_x[newest]} - {hist_x[i][15], hist_x[i]};
            mag = delta[16] ? 17'(-delta) : 17'(delta);
            if (mag > {1'b0, thresh} || i == 0) begin
                res.valid    = 1'b1;
                res.elapsed  = hist_t[newest] - hist_t[i];
                res.distance = saturated_fling(delta, res.elapsed);
                return res;
            end
        end
        return res;
    endfunction

    // track every handshake at the rising edge
    always @(posedge i_clk) begin : track
        t_fling want;
        if (!i_rst_n) begin
            hist_count   = 0;
            thresh       = THRESH_RESET;
            gain         = GAIN_RESET;
            o_fail_count = 0;
            expected_flings.delete();
        end else begin
            // result transaction against the oldest expectation
            if (i_out_valid && i_out_ready) begin
                if (expected_flings.size() == 0) begin
                    $display("%0t: unexpected result valid=%0d distance=%0d elapsed=%0d",
                             $time, i_fling_valid, i_fling_distance, i_elapsed_ms);
                    o_fail_count++;
                end else begin
                    want = expected_flings.pop_front();
                    if (i_fling_valid !== want.valid) begin
                        $display("%0t: fling_valid expected %0d actual %0d",
                                 $time, want.valid, i_fling_valid);
                        o_fail_count++;
                    end
                    if (i_fling_distance !== want.distance) begin
                        $display("%0t: fling_distance expected %0d actual %0d",
                                 $time, want.distance, i_fling_distance);
                        o_fail_count++;
                    end
                    if (i_elapsed_ms !== want.elapsed) begin
                        $display("%0t: elapsed_ms expected %0d actual %0d",
                                 $time, want.elapsed, i_elapsed_ms);
                        o_fail_count++;
                    end
                end
            end

            // register writes
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_THRESH)
                    thresh = i_cfg_data;
                else
                    gain = i_cfg_data;
            end

            // input transaction updates the history or queues a prediction
            if (i_in_valid && i_in_ready) begin
                case (t_action'(i_action))
                    ACT_ADD: begin
                        if (hist_count >= DEPTH) begin
                            for (int k = 0; k < DEPTH - 1; k++) begin
                                hist_x[k] = hist_x[k + 1];
                                hist_y[k] = hist_y[k + 1];
                                hist_t[k] = hist_t[k + 1];
                            end
                            hist_count = DEPTH - 1;
                        end
                        hist_x[hist_count] = i_pos_x;
                        hist_y[hist_count] = i_pos_y;
                        hist_t[hist_count] = i_time_ms;
                        hist_count++;
                    end
                    ACT_QUERY_Y, ACT_QUERY_X: begin
                        want = predict_fling(i_action == ACT_QUERY_Y);
                        if (want.valid)
                            hist_count = 0;
                        expected_flings.push_back(want);
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_pending = expected_flings.size();
    end

endmodule

/* tb/sv/testbench.sv */
// top of the touch fling estimator testbench: stimulus, result sink and verdict
`timescale 1ns / 1ps

module testbench;
    import tfe_pkg::*;

    localparam int     DRAIN_CYCLES = 80;
    localparam int     CHUNK_ITEMS  = 150;
    localparam longint LIMIT_NS     = 20_000_000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         action;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [31:0]        time_ms;
    logic               out_valid;
    logic               out_ready;
    logic               fling_valid;
    logic signed [31:0] fling_distance;
    logic [31:0]        elapsed_ms;
    logic               cfg_we;
    logic               cfg_index;
    logic [15:0]        cfg_data;

    int fail_count;
    int pending;
    int items_sent;
    bit quiet_run;

    touch_fling_estimator DUT (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_action         (action),
        .i_pos_x          (pos_x),
        .i_pos_y          (pos_y),
        .i_time_ms        (time_ms),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_fling_valid    (fling_valid),
        .o_fling_distance (fling_distance),
        .o_elapsed_ms     (elapsed_ms),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    tfe_fling_checker fling_check (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_action         (action),
        .i_pos_x          (pos_x),
        .i_pos_y          (pos_y),
        .i_time_ms        (time_ms),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_fling_valid    (fling_valid),
        .i_fling_distance (fling_distance),
        .i_elapsed_ms     (elapsed_ms),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // 20 ns clock
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // hard stop
    initial begin
        #(LIMIT_NS);
        $display("touch_fling_estimator: mismatch");
        $finish;
    end

    // result side: random stall before each result transaction
    initial begin : result_sink
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            stall = quiet_run ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // one input transaction after a random gap
    task automatic send_item(t_action act, logic [15:0] x, logic [15:0] y, logic [31:0] t);
        int gap;
        gap = quiet_run ? 0 : $urandom_range(0, 11);
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        pos_x    <= x;
        pos_y    <= y;
        time_ms  <= t;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (act != ACT_NONE)
            items_sent++;
        if ($urandom_range(0, 39) == 0)
            quiet_run = !quiet_run;
    endtask

    // wait until every result is out and the block has gone quiet
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_phase(logic [15:0] thresh, logic [15:0] gain);
        drain();
        write_reg(CFG_THRESH, thresh);
        write_reg(CFG_GAIN, gain);
    endtask

    // a swipe: a run of samples with a drift, then a query on one axis
    task automatic send_gesture();
        int          n;
        int          dx;
        int          dy;
        int          jump;
        logic [15:0] px;
        logic [15:0] py;
        logic [31:0] stamp;
        logic        frozen;
        n      = $urandom_range(2, 8);
        px     = 16'($urandom);
        py     = 16'($urandom);
        stamp  = $urandom;
        dx     = int'($urandom_range(0, 40)) - 20;
        dy     = int'($urandom_range(0, 40)) - 20;
        frozen = ($urandom_range(0, 15) == 0);
        for (int k = 0; k < n; k++) begin
            send_item(ACT_ADD, px, py, stamp);
            jump = ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, 65535)) - 32768 : 0;
            px   = px + 16'(dx + int'($urandom_range(0, 6)) - 3 + jump);
            py   = py + 16'(dy + int'($urandom_range(0, 6)) - 3 - jump);
            if (!frozen)
                stamp = stamp + (($urandom_range(0, 19) == 0) ? $urandom
                                                              : $urandom_range(0, 40));
        end
        send_item($urandom_range(0, 1) ? ACT_QUERY_X : ACT_QUERY_Y,
                  16'($urandom), 16'($urandom), $urandom);
    endtask

    // stray transactions: ignored codes, lone queries, random samples
    task automatic send_noise();
        case ($urandom_range(0, 2))
            0: send_item(ACT_NONE, 16'($urandom), 16'($urandom), $urandom);
            1: send_item($urandom_range(0, 1) ? ACT_QUERY_X : ACT_QUERY_Y,
                         16'($urandom), 16'($urandom), $urandom);
            default: send_item(ACT_ADD, 16'($urandom), 16'($urandom), $urandom);
        endcase
    endtask

    task automatic run_random(int count);
        int target;
        target = items_sent + count;
        while (items_sent < target) begin
            if ($urandom_range(0, 4) == 0)
                send_noise();
            else
                send_gesture();
        end
    endtask

    // stimulus and verdict
    initial begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        action     = ACT_ADD;
        pos_x      = '0;
        pos_y      = '0;
        time_ms    = '0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_THRESH;
        cfg_data   = '0;
        items_sent = 0;
        quiet_run  = 1'b0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // too few samples, then ignored code
        send_item(ACT_QUERY_Y, 16'h0, 16'h0, 32'h0);
        send_item(ACT_ADD, 16'h0000, 16'h0000, 32'd100);
        send_item(ACT_QUERY_X, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(ACT_NONE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        // zero elapsed with a far move saturates
        send_item(ACT_ADD, 16'h7FFF, 16'h8000, 32'd100);
        send_item(ACT_QUERY_X, 16'h0, 16'h0, 32'h0);
        // timestamp wrap with the widest negative move
        send_item(ACT_ADD, 16'h8000, 16'h7FFF, 32'hFFFF_FFF0);
        send_item(ACT_ADD, 16'h7FFF, 16'h8000, 32'h0000_0010);
        send_item(ACT_QUERY_Y, 16'h0, 16'h0, 32'h0);
        // no move and no elapsed time
        send_item(ACT_ADD, 16'd5, 16'd5, 32'd1000);
        send_item(ACT_ADD, 16'd5, 16'd5, 32'd1000);
        send_item(ACT_QUERY_X, 16'h0, 16'h0, 32'h0);
        // window overflow, small moves walk back to the oldest
        for (int k = 0; k < 7; k++)
            send_item(ACT_ADD, 16'(2 * k), 16'(-k), 32'(2000 + 10 * k));
        send_item(ACT_QUERY_Y, 16'h0, 16'h0, 32'h0);

        run_random(CHUNK_ITEMS);

        // zero threshold and full gain: overflow on a short interval
        set_phase(16'd0, 16'hFFFF);
        send_item(ACT_ADD, 16'd0, 16'd0, 32'd50);
        send_item(ACT_ADD, 16'hFFFF, 16'd100, 32'd51);
        send_item(ACT_QUERY_X, 16'h0, 16'h0, 32'h0);
        send_item(ACT_ADD, 16'h8000, 16'h7FFF, 32'd7);
        send_item(ACT_ADD, 16'h7FFF, 16'h8000, 32'd8);
        send_item(ACT_QUERY_X, 16'h0, 16'h0, 32'h0);
        run_random(CHUNK_ITEMS);

        for (int p = 0; p < 5; p++) begin
            case (p)
                0: set_phase(16'hFFFF, 16'd0);
                1: set_phase(16'd20, GAIN_RESET);
                2: set_phase(16'($urandom), 16'($urandom));
                3: set_phase(16'd5, 16'd128);
                default: set_phase(16'hFFFF, 16'hFFFF);
            endcase
            run_random(CHUNK_ITEMS);
        end

        drain();
        if (fail_count == 0)
            $display("touch_fling_estimator: match");
        else
            $display("touch_fling_estimator: mismatch");
        $finish;
    end

endmodule

/* touch_fling_estimator.f */
design/tfe_pkg.sv
design/tfe_ctrl.sv
design/tfe_datapath.sv
design/touch_fling_estimator.sv
tb/sv/tfe_fling_checker.sv
tb/sv/testbench.sv
